[rtl/charge_session_authorization_fsm_top_defines.svh]
// Assertion macros shared by the charging session authorization RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CHARGE_SESSION_AUTHORIZATION_FSM_TOP_DEFINES_SVH
`define CHARGE_SESSION_AUTHORIZATION_FSM_TOP_DEFINES_SVH
`ifndef SYNTH
// Property checked on the rising clock edge, disabled while reset is asserted.
`define CSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked on every rising clock edge, reset included.
`define CSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSA_ASSERT(lbl, clk, rstn, prop, msg)
`define CSA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/csa_pkg.sv]
// Types, codes and constants of the charging session authorization block.
// No dependencies; used by the interfaces, csa_step and the top level.
`timescale 1ns / 1ps

package csa_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COUNT_BITS = 20;
  localparam int TIMEOUT_W  = 20;
  localparam int SRC_BITS   = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_OPEN_MASK   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CANCEL_MASK = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NOPLUG_TMO  = 2'd2;

  localparam logic [SRC_BITS-1:0]  OPEN_MASK_RST   = 7'h7F;
  localparam logic [SRC_BITS-1:0]  CANCEL_MASK_RST = 7'h7F;
  localparam logic [TIMEOUT_W-1:0] NOPLUG_TMO_RST  = 20'd6000;

  // Item function codes.
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_CLR  = 2'd2;

  // Pilot voltage classes.
  localparam logic [2:0] PILOT_12V = 3'd0;
  localparam logic [2:0] PILOT_9V  = 3'd1;
  localparam logic [2:0] PILOT_2V  = 3'd4;
  localparam logic [2:0] PILOT_4V  = 3'd5;

  // Fault handler levels.
  localparam logic [1:0] COND_SUSPEND = 2'd1;
  localparam logic [1:0] COND_CANCEL  = 2'd2;

  // Stop reasons.
  localparam logic [1:0] STOP_NONE   = 2'd0;
  localparam logic [1:0] STOP_ERROR  = 2'd1;
  localparam logic [1:0] STOP_REMOTE = 2'd2;

  // Close source codes beyond the cancel request bits.
  localparam logic [3:0] CL_SERIOUS = 4'd8;
  localparam logic [3:0] CL_NOPLUG  = 4'd9;
  localparam logic [3:0] CL_DRAWN   = 4'd10;

  // Open sources whose request is acknowledged: rfid, bt, net and noauth.
  localparam logic [SRC_BITS-1:0] CONSUME_MASK = 7'b010_0111;

  // Bit of the emergency-stop flag in the cancel requests.
  localparam int EMER_BIT = 6;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_UNAUTH = 3'd1,
    MODE_AUTH   = 3'd2,
    MODE_REQ    = 3'd3,
    MODE_CHG    = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  req;
    logic [2:0]            osrc;
    logic [3:0]            csrc;
    logic [COUNT_BITS-1:0] cnt;
  } chan_st_t;

  typedef struct packed {
    logic [SRC_BITS-1:0]  open_enable_mask;
    logic [SRC_BITS-1:0]  cancel_enable_mask;
    logic [TIMEOUT_W-1:0] noplug_timeout;
  } csa_cfg_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [CH_BITS-1:0]  channel;
    logic [2:0]          pilot_level;
    logic                evse_three_dot;
    logic [SRC_BITS-1:0] open_requests;
    logic [SRC_BITS-1:0] cancel_requests;
    logic                safety_fault;
    logic                fota_active;
    logic [1:0]          charge_condition;
    logic                remote_suspend;
    logic                reset_prepare;
  } csa_item_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic                authorized;
    logic                charge_enable;
    logic [1:0]          stop_reason;
    logic [2:0]          open_source;
    logic [3:0]          close_source;
    logic                request_pending;
    logic [SRC_BITS-1:0] consumed_open;
    logic                clear_faults;
  } csa_res_t;

endpackage

[rtl/csa_if.sv]
// Handshake channel interfaces: item input, result output and register writes.
// Depends on csa_pkg for field widths.
`timescale 1ns / 1ps

interface csa_in_if import csa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [CH_BITS-1:0]  channel;
  logic [2:0]          pilot_level;
  logic                evse_three_dot;
  logic [SRC_BITS-1:0] open_requests;
  logic [SRC_BITS-1:0] cancel_requests;
  logic                safety_fault;
  logic                fota_active;
  logic [1:0]          charge_condition;
  logic                remote_suspend;
  logic                reset_prepare;

  modport source (
    output valid, func, channel, pilot_level, evse_three_dot, open_requests,
           cancel_requests, safety_fault, fota_active, charge_condition,
           remote_suspend, reset_prepare,
    input  ready
  );
  modport sink (
    input  valid, func, channel, pilot_level, evse_three_dot, open_requests,
           cancel_requests, safety_fault, fota_active, charge_condition,
           remote_suspend, reset_prepare,
    output ready
  );
endinterface

interface csa_out_if import csa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic                authorized;
  logic                charge_enable;
  logic [1:0]          stop_reason;
  logic [2:0]          open_source;
  logic [3:0]          close_source;
  logic                request_pending;
  logic [SRC_BITS-1:0] consumed_open;
  logic                clear_faults;

  modport source (
    output valid, mode, authorized, charge_enable, stop_reason, open_source,
           close_source, request_pending, consumed_open, clear_faults,
    input  ready
  );
  modport sink (
    input  valid, mode, authorized, charge_enable, stop_reason, open_source,
           close_source, request_pending, consumed_open, clear_faults,
    output ready
  );
endinterface

interface csa_cfg_if import csa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[rtl/charge_session_authorization_fsm_top.sv]
// Each result passes through the stage-one register and then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the per-channel
// state memory is read at acceptance and written back when the transaction leaves
// stage one, with a forward path for a back-to-back transaction on the same channel.
// Reset (rst_n, synchronous, active low): all channels read as idle with cleared
// state through per-entry valid bits; registers take their reset values at once.
`timescale 1ns / 1ps
`include "charge_session_authorization_fsm_top_defines.svh"

module charge_session_authorization_fsm_top import csa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  csa_in_if.sink    in_ch,
  csa_out_if.source out_ch,
  csa_cfg_if.sink   cfg_ch
);

  // Register file.
  csa_cfg_t cfg_r;
  csa_cfg_t cfg_nxt;

  // Channel state memory with valid bits that stand in for a clearing pass.
  chan_st_t            mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  chan_st_t            rd_data_r;
  logic                rd_vld_r;

  // Stage 1: item being updated.
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  csa_item_t          s1_item_r;
  logic               fwd_hit_r;
  chan_st_t           fwd_st_r;
  logic               s1_adv;
  logic               in_acc;
  csa_item_t          in_item;
  chan_st_t           cur_st;
  chan_st_t           new_st;
  csa_res_t           new_res;

  // Output register.
  logic     out_valid_r;
  logic     out_valid_nxt;
  csa_res_t out_res_r;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_OPEN_MASK:   cfg_nxt.open_enable_mask   = cfg_ch.data[SRC_BITS-1:0];
        REG_CANCEL_MASK: cfg_nxt.cancel_enable_mask = cfg_ch.data[SRC_BITS-1:0];
        REG_NOPLUG_TMO:  cfg_nxt.noplug_timeout     = cfg_ch.data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_enable_mask   <= OPEN_MASK_RST;
      cfg_r.cancel_enable_mask <= CANCEL_MASK_RST;
      cfg_r.noplug_timeout     <= NOPLUG_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    in_item.func             = in_ch.func;
    in_item.channel          = in_ch.channel;
    in_item.pilot_level      = in_ch.pilot_level;
    in_item.evse_three_dot   = in_ch.evse_three_dot;
    in_item.open_requests    = in_ch.open_requests;
    in_item.cancel_requests  = in_ch.cancel_requests;
    in_item.safety_fault     = in_ch.safety_fault;
    in_item.fota_active      = in_ch.fota_active;
    in_item.charge_condition = in_ch.charge_condition;
    in_item.remote_suspend   = in_ch.remote_suspend;
    in_item.reset_prepare    = in_ch.reset_prepare;
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  // The read at acceptance misses a write-back to the same channel at that
  // same edge, so the written value is held and takes precedence.
  assign cur_st = fwd_hit_r ? fwd_st_r : (rd_vld_r ? rd_data_r : '0);

  csa_step u_step (
    .st_i   (cur_st),
    .item_i (s1_item_r),
    .cfg_i  (cfg_r),
    .st_o   (new_st),
    .res_o  (new_res)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_item_r.channel] <= new_st;
    end
    if (in_acc) begin
      rd_data_r <= mem[in_ch.channel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        vld_r[s1_item_r.channel] <= 1'b1;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
      rd_vld_r  <= vld_r[in_ch.channel];
      fwd_hit_r <= s1_adv && (s1_item_r.channel == in_ch.channel);
      fwd_st_r  <= new_st;
    end
    if (s1_adv) begin
      out_res_r <= new_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mode            = out_res_r.mode;
  assign out_ch.authorized      = out_res_r.authorized;
  assign out_ch.charge_enable   = out_res_r.charge_enable;
  assign out_ch.stop_reason     = out_res_r.stop_reason;
  assign out_ch.open_source     = out_res_r.open_source;
  assign out_ch.close_source    = out_res_r.close_source;
  assign out_ch.request_pending = out_res_r.request_pending;
  assign out_ch.consumed_open   = out_res_r.consumed_open;
  assign out_ch.clear_faults    = out_res_r.clear_faults;

  `CSA_ASSERT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r), "stalled stage lost its transaction")
  `CSA_ASSERT(a_acc_loads, clk, rst_n, in_acc |=> s1_valid_r, "accepted transaction not in stage one")
  `CSA_ASSERT(a_consume_onehot, clk, rst_n, out_valid_r |-> $onehot0(out_res_r.consumed_open), "more than one open request acknowledged")
  `CSA_ASSERT(a_clear_grant, clk, rst_n, out_valid_r && out_res_r.clear_faults |-> out_res_r.mode == MODE_AUTH && out_res_r.open_source != 3'd0, "fault clear without a grant")
  `CSA_ASSERT(a_enable_req, clk, rst_n, out_valid_r && out_res_r.charge_enable |-> out_res_r.request_pending && out_res_r.stop_reason == STOP_NONE, "charger enabled without request")

endmodule

[rtl/csa_step.sv]
// Next-state and result logic for one transaction on one channel.
// Depends on csa_pkg; instantiated by charge_session_authorization_fsm_top.
`timescale 1ns / 1ps

module csa_step import csa_pkg::*; (
  input  chan_st_t  st_i,
  input  csa_item_t item_i,
  input  csa_cfg_t  cfg_i,
  output chan_st_t  st_o,
  output csa_res_t  res_o
);

  logic [SRC_BITS-1:0] open_bits;
  logic [SRC_BITS-1:0] open_hot;
  logic [2:0]          open_idx;
  logic [SRC_BITS-1:0] cancel_bits;
  logic [2:0]          cancel_idx;
  logic                cancel_fire;
  logic [3:0]          cancel_code;
  logic                emer;
  logic                unplugged;
  logic                plugged;
  logic                open_ok;
  logic [COUNT_BITS:0] cnt_inc;
  chan_st_t            st;
  logic                enable;
  logic [1:0]          reason;
  logic [SRC_BITS-1:0] consumed;
  logic                clearf;

  // Lowest set request wins; the code is its bit position plus one.
  always_comb begin
    open_bits   = item_i.open_requests & cfg_i.open_enable_mask;
    cancel_bits = item_i.cancel_requests & cfg_i.cancel_enable_mask;
    open_hot    = open_bits & (~open_bits + 1'b1);
    open_idx    = '0;
    cancel_idx  = '0;
    for (int i = SRC_BITS - 1; i >= 0; i--) begin
      if (open_bits[i]) begin
        open_idx = 3'(i + 1);
      end
      if (cancel_bits[i]) begin
        cancel_idx = 3'(i + 1);
      end
    end
  end

  assign cancel_fire = (cancel_idx != '0) || (item_i.charge_condition >= COND_CANCEL);
  assign cancel_code = (cancel_idx != '0) ? {1'b0, cancel_idx} : CL_SERIOUS;
  assign emer        = cfg_i.cancel_enable_mask[EMER_BIT] & item_i.cancel_requests[EMER_BIT];
  assign open_ok     = !item_i.safety_fault && !emer && !item_i.fota_active &&
                       (open_idx != '0);
  assign unplugged   = (item_i.pilot_level == PILOT_12V) || (item_i.pilot_level == PILOT_4V);
  assign plugged     = (item_i.pilot_level >= PILOT_9V) && (item_i.pilot_level <= PILOT_2V);
  assign cnt_inc     = {1'b0, st_i.cnt} + 1'b1;

  always_comb begin
    st       = st_i;
    enable   = 1'b0;
    reason   = STOP_NONE;
    consumed = '0;
    clearf   = 1'b0;
    unique case (item_i.func)
      FUNC_SET: begin
        st.req = 1'b1;
      end
      FUNC_CLR: begin
        st.req = 1'b0;
      end
      FUNC_TICK: begin
        unique case (st_i.mode)
          MODE_IDLE: begin
            if (item_i.reset_prepare) begin
              st.mode = MODE_UNAUTH;
            end
          end
          MODE_UNAUTH: begin
            if (open_ok) begin
              st.osrc  = open_idx;
              st.mode  = MODE_AUTH;
              st.req   = 1'b1;
              st.cnt   = '0;
              consumed = open_hot & CONSUME_MASK;
              clearf   = 1'b1;
            end
          end
          MODE_AUTH: begin
            if (unplugged) begin
              // Counter saturates at its all-ones value.
              if (!cnt_inc[COUNT_BITS]) begin
                st.cnt = cnt_inc[COUNT_BITS-1:0];
              end
              if (32'(st.cnt) >= 32'(cfg_i.noplug_timeout)) begin
                st.csrc = CL_NOPLUG;
                st.mode = MODE_UNAUTH;
                st.cnt  = '0;
              end
            end else if (plugged) begin
              st.req  = 1'b1;
              st.mode = MODE_REQ;
            end
            if (cancel_fire) begin
              st.csrc = cancel_code;
              st.req  = 1'b0;
              st.mode = MODE_UNAUTH;
            end
          end
          MODE_REQ: begin
            if (unplugged) begin
              st.mode = MODE_AUTH;
            end else if (plugged && item_i.evse_three_dot) begin
              st.mode = MODE_CHG;
            end
            if (cancel_fire) begin
              st.csrc = cancel_code;
              st.req  = 1'b0;
              st.mode = MODE_UNAUTH;
            end
          end
          MODE_CHG: begin
            if (unplugged) begin
              st.mode = MODE_UNAUTH;
              st.req  = 1'b0;
              st.csrc = CL_DRAWN;
            end else if (cancel_fire) begin
              st.csrc = cancel_code;
              st.req  = 1'b0;
              st.mode = MODE_UNAUTH;
            end
          end
          default: begin
            st.mode = MODE_UNAUTH;
          end
        endcase
        // Without a request the channel always drops back to unauthorized.
        if (st.req) begin
          if (item_i.charge_condition == COND_SUSPEND) begin
            reason = STOP_ERROR;
          end else if (item_i.remote_suspend) begin
            reason = STOP_REMOTE;
          end else begin
            enable = 1'b1;
          end
        end else begin
          st.mode = MODE_UNAUTH;
        end
      end
      default: begin
      end
    endcase
  end

  assign st_o = st;

  always_comb begin
    res_o.mode            = st.mode;
    res_o.authorized      = (st.mode == MODE_AUTH) || (st.mode == MODE_REQ) ||
                            (st.mode == MODE_CHG);
    res_o.charge_enable   = enable;
    res_o.stop_reason     = reason;
    res_o.open_source     = st.osrc;
    res_o.close_source    = st.csrc;
    res_o.request_pending = st.req;
    res_o.consumed_open   = consumed;
    res_o.clear_faults    = clearf;
  end

endmodule
